// ----- rtl/stscan_pkg.sv -----
`timescale 1ns / 1ps

package stscan_pkg;

   // Token length limit; bytes past MAX_TOKEN-1 in one token are dropped.
   localparam int MAX_TOKEN   = 1024;
   localparam int TOKEN_LEN_W = $clog2(MAX_TOKEN);

   // Results per input word, and the result queue that absorbs them.
   localparam int RES_MAX     = 3;
   localparam int RES_CNT_W   = $clog2(RES_MAX + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   // Input word kinds.
   localparam logic KIND_TEXT  = 1'b0;
   localparam logic KIND_BEGIN = 1'b1;

   // Result kinds.
   localparam logic [1:0] RK_BYTE = 2'd0;
   localparam logic [1:0] RK_END  = 2'd1;
   localparam logic [1:0] RK_EOT  = 2'd2;
   localparam logic [1:0] RK_STOP = 2'd3;

   typedef enum logic [2:0] {
      MODE_SKIP  = 3'd0,
      MODE_WORD  = 3'd1,
      MODE_QUOTE = 3'd2,
      MODE_LINE  = 3'd3,
      MODE_BLOCK = 3'd4,
      MODE_DONE  = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } stscan_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  out_char;
      logic [15:0] line_number;
      logic        last;
   } stscan_rsp_type;

   // All results caused by one input word, in order.
   typedef struct packed {
      logic [RES_CNT_W-1:0]        count;
      stscan_rsp_type [RES_MAX-1:0] item;
   } stscan_batch_type;

endpackage

// ----- rtl/stscan_core.sv -----
`timescale 1ns / 1ps

module stscan_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  stscan_pkg::stscan_req_type  in_word,
   input  logic                        allow_line_break,
   output stscan_pkg::stscan_batch_type batch
);

   stscan_pkg::scan_mode_type          mode_ff, mode_in;
   logic                               slash_ff, slash_in;
   logic                               star_ff, star_in;
   logic [stscan_pkg::TOKEN_LEN_W-1:0] len_ff, len_in;
   logic [15:0]                        lc_ff, lc_in;
   logic [stscan_pkg::RES_CNT_W-1:0]   n;
   logic                               run_word;
   logic                               run_skip;
   logic [7:0]                         ch;

   function automatic stscan_pkg::stscan_rsp_type make_rsp(
      input logic [1:0]  kind,
      input logic [7:0]  c,
      input logic [15:0] line
   );
      stscan_pkg::stscan_rsp_type r;
      r.result_kind = kind;
      r.out_char    = (kind == stscan_pkg::RK_BYTE) ? c : 8'd0;
      r.line_number = line;
      r.last        = 1'b0;
      return r;
   endfunction

   assign ch = in_word.ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= stscan_pkg::MODE_SKIP;
         slash_ff <= 1'b0;
         star_ff  <= 1'b0;
         len_ff   <= '0;
         lc_ff    <= '0;
      end else if (go) begin
         mode_ff  <= mode_in;
         slash_ff <= slash_in;
         star_ff  <= star_in;
         len_ff   <= len_in;
         lc_ff    <= lc_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      slash_in = slash_ff;
      star_in  = star_ff;
      len_in   = len_ff;
      lc_in    = lc_ff;
      batch    = '0;
      n        = '0;
      run_word = 1'b0;
      run_skip = 1'b0;

      if (in_word.kind == stscan_pkg::KIND_BEGIN) begin
         mode_in  = stscan_pkg::MODE_SKIP;
         slash_in = 1'b0;
         star_in  = 1'b0;
         len_in   = '0;
         lc_in    = '0;
      end else begin
         case (mode_ff)
            stscan_pkg::MODE_WORD: begin
               run_word = 1'b1;
            end
            stscan_pkg::MODE_QUOTE: begin
               if (ch == stscan_pkg::CH_QUOTE || ch == stscan_pkg::CH_NUL) begin
                  batch.item[n] = make_rsp(stscan_pkg::RK_END, ch, lc_in);
                  n = n + 1'b1;
                  mode_in = stscan_pkg::MODE_SKIP;
                  len_in  = '0;
                  if (ch == stscan_pkg::CH_NUL) begin
                     batch.item[n] = make_rsp(stscan_pkg::RK_EOT, ch, lc_in);
                     n = n + 1'b1;
                     mode_in = stscan_pkg::MODE_DONE;
                  end
               end else begin
                  if (ch == stscan_pkg::CH_NL && lc_in != stscan_pkg::LINE_MAX) begin
                     lc_in = lc_in + 16'd1;
                  end
                  if (len_in < stscan_pkg::TOKEN_LEN_W'(stscan_pkg::MAX_TOKEN - 1)) begin
                     len_in = len_in + 1'b1;
                     batch.item[n] = make_rsp(stscan_pkg::RK_BYTE, ch, lc_in);
                     n = n + 1'b1;
                  end
               end
            end
            stscan_pkg::MODE_LINE: begin
               if (ch == stscan_pkg::CH_NUL || ch == stscan_pkg::CH_NL) begin
                  mode_in  = stscan_pkg::MODE_SKIP;
                  run_skip = 1'b1;
               end
            end
            stscan_pkg::MODE_BLOCK: begin
               if (ch == stscan_pkg::CH_NUL) begin
                  mode_in  = stscan_pkg::MODE_SKIP;
                  run_skip = 1'b1;
               end else begin
                  if (ch == stscan_pkg::CH_NL && lc_in != stscan_pkg::LINE_MAX) begin
                     lc_in = lc_in + 16'd1;
                  end
                  if (ch == stscan_pkg::CH_SLASH && star_ff) begin
                     mode_in = stscan_pkg::MODE_SKIP;
                     star_in = 1'b0;
                  end else begin
                     star_in = (ch == stscan_pkg::CH_STAR);
                  end
               end
            end
            stscan_pkg::MODE_DONE: begin
               batch.item[n] = make_rsp(stscan_pkg::RK_EOT, ch, lc_in);
               n = n + 1'b1;
            end
            default: begin
               mode_in = stscan_pkg::MODE_SKIP;
               if (slash_ff) begin
                  slash_in = 1'b0;
                  if (ch == stscan_pkg::CH_SLASH) begin
                     mode_in = stscan_pkg::MODE_LINE;
                  end else if (ch == stscan_pkg::CH_STAR) begin
                     mode_in = stscan_pkg::MODE_BLOCK;
                     star_in = 1'b0;
                  end else begin
                     // lone slash opens a word; emit it, then treat ch as a word byte
                     mode_in = stscan_pkg::MODE_WORD;
                     len_in  = '0;
                     len_in  = len_in + 1'b1;
                     batch.item[n] = make_rsp(stscan_pkg::RK_BYTE, stscan_pkg::CH_SLASH,
                                              lc_in);
                     n = n + 1'b1;
                     run_word = 1'b1;
                  end
               end else begin
                  run_skip = 1'b1;
               end
            end
         endcase

         if (run_word) begin
            if (ch > stscan_pkg::CH_SPACE) begin
               if (len_in < stscan_pkg::TOKEN_LEN_W'(stscan_pkg::MAX_TOKEN - 1)) begin
                  len_in = len_in + 1'b1;
                  batch.item[n] = make_rsp(stscan_pkg::RK_BYTE, ch, lc_in);
                  n = n + 1'b1;
               end
            end else begin
               batch.item[n] = make_rsp(stscan_pkg::RK_END, ch, lc_in);
               n = n + 1'b1;
               mode_in  = stscan_pkg::MODE_SKIP;
               len_in   = '0;
               run_skip = 1'b1;
            end
         end

         if (run_skip) begin
            if (ch == stscan_pkg::CH_NUL) begin
               batch.item[n] = make_rsp(stscan_pkg::RK_EOT, ch, lc_in);
               n = n + 1'b1;
               mode_in = stscan_pkg::MODE_DONE;
            end else if (ch == stscan_pkg::CH_NL) begin
               if (lc_in != stscan_pkg::LINE_MAX) begin
                  lc_in = lc_in + 16'd1;
               end
               if (!allow_line_break) begin
                  batch.item[n] = make_rsp(stscan_pkg::RK_STOP, ch, lc_in);
                  n = n + 1'b1;
               end
            end else if (ch <= stscan_pkg::CH_SPACE) begin
               // drop whitespace
            end else if (ch == stscan_pkg::CH_SLASH) begin
               slash_in = 1'b1;
            end else if (ch == stscan_pkg::CH_QUOTE) begin
               mode_in = stscan_pkg::MODE_QUOTE;
               len_in  = '0;
            end else begin
               mode_in = stscan_pkg::MODE_WORD;
               len_in  = '0;
               if (len_in < stscan_pkg::TOKEN_LEN_W'(stscan_pkg::MAX_TOKEN - 1)) begin
                  len_in = len_in + 1'b1;
                  batch.item[n] = make_rsp(stscan_pkg::RK_BYTE, ch, lc_in);
                  n = n + 1'b1;
               end
            end
         end
      end

      batch.count = n;
   end

endmodule

// ----- rtl/stscan_rqueue.sv -----
`timescale 1ns / 1ps

module stscan_rqueue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  stscan_pkg::stscan_batch_type batch,
   input  logic                         pop_ready,
   output logic                         room,
   output logic                         head_valid,
   output stscan_pkg::stscan_rsp_type   head
);

   stscan_pkg::stscan_rsp_type         q_ff [stscan_pkg::QUEUE_DEPTH];
   stscan_pkg::stscan_rsp_type         q_in [stscan_pkg::QUEUE_DEPTH];
   stscan_pkg::stscan_rsp_type         rsp_tmp;
   logic [stscan_pkg::QUEUE_CNT_W-1:0] count_ff, count_in, base;
   logic [stscan_pkg::QUEUE_IDX_W-1:0] slot;
   logic                               pop;

   assign head_valid = (count_ff != '0);
   assign head       = q_ff[0];
   assign pop        = head_valid && pop_ready;
   // a full batch must fit before the next word is scanned
   assign room = (count_ff <= stscan_pkg::QUEUE_CNT_W'(stscan_pkg::QUEUE_DEPTH -
                                                      stscan_pkg::RES_MAX));

   always_comb begin
      base    = count_ff - stscan_pkg::QUEUE_CNT_W'(pop);
      rsp_tmp = '0;
      slot    = '0;
      for (int i = 0; i < stscan_pkg::QUEUE_DEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      q_in[stscan_pkg::QUEUE_DEPTH - 1] = q_ff[stscan_pkg::QUEUE_DEPTH - 1];
      for (int j = 0; j < stscan_pkg::RES_MAX; j++) begin
         if (push && stscan_pkg::RES_CNT_W'(j) < batch.count) begin
            rsp_tmp      = batch.item[j];
            rsp_tmp.last = (stscan_pkg::RES_CNT_W'(j) == batch.count - 1'b1);
            slot         = stscan_pkg::QUEUE_IDX_W'(base + stscan_pkg::QUEUE_CNT_W'(j));
            q_in[slot]   = rsp_tmp;
         end
      end
      count_in = base + (push ? stscan_pkg::QUEUE_CNT_W'(batch.count) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

// ----- rtl/script_token_scanner.sv -----
`timescale 1ns / 1ps

// Script token scanner: takes a text stream one byte per word on the req_
// channel and returns token bytes, end-of-token, end-of-text and line-break
// stop markers on the rsp_ channel, each tagged with the newline count of the
// current session and a last flag on the final result caused by that byte.
// Whitespace (bytes of 32 or less), line comments and block comments are
// skipped; quoted strings keep their spaces. A req_ word with kind set begins
// a new session. Rate: one input byte per cycle while rsp_ready stays high
// and each byte yields at most one result; a byte that yields two or three
// results occupies the single result port until all are taken, and the
// four-word result queue paces the input accordingly. A byte passes the
// input register, then the scan logic into the result queue.
// csr_wr_en / csr_wr_data write allow_line_break (reset 1); write it only
// while the block is idle.

module script_token_scanner (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  stscan_pkg::stscan_req_type req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output stscan_pkg::stscan_rsp_type rsp_word,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   stscan_pkg::stscan_req_type   in_word_ff;
   logic                         in_valid_ff, in_valid_in;
   logic                         alb_ff;
   logic                         go;
   logic                         room;
   stscan_pkg::stscan_batch_type batch;

   // Scan the held word once its whole result batch fits in the queue;
   // take a new word whenever the input register empties this cycle.
   assign go          = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || go;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         alb_ff      <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            alb_ff <= csr_wr_data;
         end
      end
   end

   // hold the payload until the scanner consumes it
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
   end

   stscan_core u_core (
      .clock            (clock),
      .reset            (reset),
      .go               (go),
      .in_word          (in_word_ff),
      .allow_line_break (alb_ff),
      .batch            (batch)
   );

   stscan_rqueue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (go),
      .batch      (batch),
      .pop_ready  (rsp_ready),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (rsp_word)
   );

endmodule

// ----- rtl/stscan_checker.sv -----
`timescale 1ns / 1ps

module stscan_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input stscan_pkg::stscan_rsp_type rsp_word
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the input side is open right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result changed while stalled");

   // a whole batch is queued at once, so a non-final result is always followed
   a_batch_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_word.last |=> rsp_valid)
      else $error("gap inside a result batch");

   // markers carry no byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.result_kind != stscan_pkg::RK_BYTE) |->
         (rsp_word.out_char == 8'd0))
      else $error("marker result with nonzero byte");

endmodule

bind script_token_scanner stscan_checker u_checker (.*);

// ----- dv/stscan_checker.sv -----
`timescale 1ns / 1ps

module stscan_scoreboard (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  stscan_pkg::stscan_req_type req_word,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  stscan_pkg::stscan_rsp_type rsp_word,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   output int                         fail_count,
   output int                         results_due,
   output int                         results_seen
);
   import stscan_pkg::*;

   // Scanner state as predicted from the accepted text words.
   scan_mode_type  mode;
   logic           slash_wait;
   logic           star_prev;
   logic           allow_break;
   int             tok_len;
   logic [15:0]    lines;

   stscan_rsp_type step_out[$];
   stscan_rsp_type pending_results[$];
   int             fails;
   int             seen;

   function automatic void put_result(input logic [1:0] kind, input logic [7:0] c);
      stscan_rsp_type r;
      if (step_out.size() >= RES_MAX) return;
      r.result_kind = kind;
      r.out_char    = (kind == RK_BYTE) ? c : CH_NUL;
      r.line_number = lines;
      r.last        = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void count_newline();
      if (lines != LINE_MAX) lines = lines + 16'd1;
   endfunction

   function automatic void keep_char(input logic [7:0] c);
      if (tok_len < MAX_TOKEN - 1) begin
         tok_len++;
         put_result(RK_BYTE, c);
      end
   endfunction

   function automatic void between_tokens(input logic [7:0] c);
      if (c == CH_NUL) begin
         put_result(RK_EOT, CH_NUL);
         mode = MODE_DONE;
      end else if (c == CH_NL) begin
         count_newline();
         if (!allow_break) put_result(RK_STOP, CH_NUL);
      end else if (c <= CH_SPACE) begin
         // whitespace: nothing to do
      end else if (c == CH_SLASH) begin
         slash_wait = 1'b1;
      end else if (c == CH_QUOTE) begin
         mode    = MODE_QUOTE;
         tok_len = 0;
      end else begin
         mode    = MODE_WORD;
         tok_len = 0;
         keep_char(c);
      end
   endfunction

   function automatic void word_char(input logic [7:0] c);
      if (c > CH_SPACE) begin
         keep_char(c);
      end else begin
         put_result(RK_END, CH_NUL);
         mode    = MODE_SKIP;
         tok_len = 0;
         between_tokens(c);
      end
   endfunction

   function automatic void scan_word(input stscan_req_type w);
      logic [7:0]     c;
      stscan_rsp_type r;
      c = w.ch;
      step_out.delete();
      if (w.kind == KIND_BEGIN) begin
         mode       = MODE_SKIP;
         slash_wait = 1'b0;
         star_prev  = 1'b0;
         tok_len    = 0;
         lines      = '0;
         return;
      end
      case (mode)
         MODE_WORD: begin
            word_char(c);
         end
         MODE_QUOTE: begin
            if (c == CH_QUOTE || c == CH_NUL) begin
               put_result(RK_END, CH_NUL);
               mode    = MODE_SKIP;
               tok_len = 0;
               if (c == CH_NUL) begin
                  put_result(RK_EOT, CH_NUL);
                  mode = MODE_DONE;
               end
            end else begin
               if (c == CH_NL) count_newline();
               keep_char(c);
            end
         end
         MODE_LINE: begin
            if (c == CH_NUL || c == CH_NL) begin
               mode = MODE_SKIP;
               between_tokens(c);
            end
         end
         MODE_BLOCK: begin
            if (c == CH_NUL) begin
               mode = MODE_SKIP;
               between_tokens(c);
            end else begin
               if (c == CH_NL) count_newline();
               if (c == CH_SLASH && star_prev) begin
                  mode      = MODE_SKIP;
                  star_prev = 1'b0;
               end else begin
                  star_prev = (c == CH_STAR);
               end
            end
         end
         MODE_DONE: begin
            put_result(RK_EOT, CH_NUL);
         end
         default: begin
            mode = MODE_SKIP;
            if (slash_wait) begin
               slash_wait = 1'b0;
               if (c == CH_SLASH) begin
                  mode = MODE_LINE;
               end else if (c == CH_STAR) begin
                  mode      = MODE_BLOCK;
                  star_prev = 1'b0;
               end else begin
                  mode    = MODE_WORD;
                  tok_len = 0;
                  keep_char(CH_SLASH);
                  word_char(c);
               end
            end else begin
               between_tokens(c);
            end
         end
      endcase
      foreach (step_out[i]) begin
         r      = step_out[i];
         r.last = (i == step_out.size() - 1);
         pending_results.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      stscan_rsp_type want;
      if (reset) begin
         mode        = MODE_SKIP;
         slash_wait  = 1'b0;
         star_prev   = 1'b0;
         allow_break = 1'b1;
         tok_len     = 0;
         lines       = '0;
         pending_results.delete();
         fails       = 0;
         seen        = 0;
      end else begin
         if (csr_wr_en) allow_break = csr_wr_data;
         if (req_valid && req_ready) scan_word(req_word);
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (pending_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result kind %0d char %02h line %0d last %0b",
                           $realtime, rsp_word.result_kind, rsp_word.out_char,
                           rsp_word.line_number, rsp_word.last);
            end else begin
               want = pending_results.pop_front();
               if (want.result_kind !== rsp_word.result_kind ||
                   want.out_char !== rsp_word.out_char ||
                   want.line_number !== rsp_word.line_number ||
                   want.last !== rsp_word.last) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: mismatch exp kind %0d char %02h line %0d last %0b,",
                              $realtime, want.result_kind, want.out_char,
                              want.line_number, want.last);
                     $display("   got kind %0d char %02h line %0d last %0b",
                              rsp_word.result_kind, rsp_word.out_char,
                              rsp_word.line_number, rsp_word.last);
                  end
               end
            end
         end
      end
      fail_count   <= fails;
      results_due  <= pending_results.size();
      results_seen <= seen;
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import stscan_pkg::*;

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           req_valid   = 1'b0;
   logic           req_ready;
   stscan_req_type req_word    = '0;
   logic           rsp_valid;
   logic           rsp_ready   = 1'b0;
   stscan_rsp_type rsp_word;
   logic           csr_wr_en   = 1'b0;
   logic           csr_wr_data = 1'b0;

   int fail_count;
   int results_due;
   int results_seen;

   // Idle odds in percent for each side; the test process changes them per phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent    = 0;

   script_token_scanner uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stscan_scoreboard u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .results_due  (results_due),
      .results_seen (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stall at random, one decision per edge.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Present one word and hold it until the scanner takes it. Idle cycles
   // go in before the word, never between raising valid and acceptance.
   task automatic send_word(input logic k, input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{kind: k, ch: c};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text(input logic [7:0] c);
      send_word(KIND_TEXT, c);
   endtask

   // The byte travels along with a begin word but must be ignored.
   task automatic send_begin();
      send_word(KIND_BEGIN, 8'($urandom_range(255)));
   endtask

   // Any nonzero byte except the one given.
   function automatic logic [7:0] byte_other_than(input logic [7:0] ex);
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      if (c == ex) c = CH_SPACE;
      return c;
   endfunction

   // Hold the sender off until every expected result is back, then give
   // the scanner a few more cycles: words that yield nothing may still be
   // in its two-stage pipe.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (results_due != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_break(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random piece of script: mostly well-formed tokens, comments and
   // whitespace, with some text ends, stray slashes and raw noise.
   task automatic send_fragment();
      int         pick;
      int         len;
      logic [7:0] c;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // bare word, ended by some whitespace byte (newline included)
         len = $urandom_range(1, 10);
         repeat (len) send_text(8'($urandom_range(33, 255)));
         send_text(8'($urandom_range(1, 32)));
      end else if (pick < 44) begin
         // quoted string, possibly empty, spaces and newlines kept
         send_text(CH_QUOTE);
         len = $urandom_range(0, 8);
         repeat (len) send_text(byte_other_than(CH_QUOTE));
         send_text(CH_QUOTE);
      end else if (pick < 54) begin
         // line comment up to the newline
         send_text(CH_SLASH);
         send_text(CH_SLASH);
         len = $urandom_range(0, 6);
         repeat (len) send_text(byte_other_than(CH_NL));
         send_text(CH_NL);
      end else if (pick < 64) begin
         // block comment with stars sprinkled in
         send_text(CH_SLASH);
         send_text(CH_STAR);
         len = $urandom_range(0, 6);
         repeat (len) begin
            if ($urandom_range(3) == 0) c = CH_STAR;
            else c = byte_other_than(CH_NUL);
            send_text(c);
         end
         send_text(CH_STAR);
         send_text(CH_SLASH);
      end else if (pick < 74) begin
         // whitespace run, newlines favored
         len = $urandom_range(1, 3);
         repeat (len) begin
            if ($urandom_range(1) == 0) c = CH_NL;
            else c = 8'($urandom_range(1, 32));
            send_text(c);
         end
      end else if (pick < 79) begin
         // text end wherever we are, a few bytes past it, new session
         send_text(CH_NUL);
         len = $urandom_range(0, 2);
         repeat (len) send_text(8'($urandom_range(255)));
         send_begin();
      end else if (pick < 89) begin
         // raw noise, now and then a begin word
         if ($urandom_range(7) == 0) send_begin();
         else send_text(8'($urandom_range(255)));
      end else if (pick < 95) begin
         // lone slash followed by anything
         send_text(CH_SLASH);
         send_text(8'($urandom_range(255)));
      end else begin
         send_begin();
      end
   endtask

   // Drain, set the register, set the pacing, then stream random script.
   task automatic run_phase(input int s_pct, input int r_pct, input logic brk);
      int start;
      settle();
      write_break(brk);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      start = words_sent;
      while (words_sent - start < 130) send_fragment();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset value of allow_line_break still in force.
      send_begin();
      send_text("a");
      send_text(8'hFF);      // high byte is a plain token byte
      send_text(CH_SPACE);   // ends the word
      send_text(CH_QUOTE);
      send_text(CH_SPACE);   // space kept inside a string
      send_text(CH_NL);      // newline kept and counted inside a string
      send_text(CH_QUOTE);
      send_text(CH_SLASH);
      send_text(CH_STAR);
      send_text(CH_SLASH);   // star-slash right after slash-star: stays open
      send_text(CH_STAR);
      send_text(CH_SLASH);   // now closed
      send_text(CH_SLASH);
      send_text(CH_SLASH);   // line comment
      send_text(CH_NL);
      send_text(CH_SLASH);
      send_text("x");        // lone slash turns into a word
      send_text(CH_NUL);     // end of token, then end of text
      send_text(8'h7F);      // past the text end
      send_begin();
      send_text(CH_SLASH);
      send_text(CH_NUL);     // slash then text end: three results
      settle();

      // Newline stop between tokens, then text end inside a string.
      write_break(1'b0);
      send_text("w");
      send_text(CH_NL);
      send_text(CH_QUOTE);
      send_text("q");
      send_text(CH_NUL);
      send_begin();

      run_phase(7, 51, 1'b0);
      run_phase(51, 7, 1'b1);
      run_phase(0, 0, 1'b0);
      settle();

      $display("Sent %0d words, checked %0d results over three pacing phases,",
               words_sent, results_seen);
      $display("with both line break settings and a full drain before each phase.");
      if (fail_count == 0 && results_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Backstop against a hung handshake.
   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
